// ===== sv/non_invite_client_transaction_fsm_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the non-INVITE client transaction block
// Shared helpers so every assertion uses the same clock, reset and report.
// ----------------------------------------------------------------------------
`ifndef NON_INVITE_CLIENT_TRANSACTION_FSM_TOP_MACROS_SVH
`define NON_INVITE_CLIENT_TRANSACTION_FSM_TOP_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define NICTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define NICTF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/nictf_pkg.sv =====
// ----------------------------------------------------------------------------
// nictf_pkg
// Types and codes shared by the non-INVITE client transaction block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nictf_pkg;

  // Event kinds carried by an input item.
  typedef enum logic [1:0] {
    OP_USER_REQ = 2'd0,
    OP_PEER_MSG = 2'd1,
    OP_TICK     = 2'd2,
    OP_TX_FAIL  = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_USE_UDP = 3'd0,
    CFG_T1      = 3'd1,
    CFG_T2      = 3'd2,
    CFG_TIMEOUT = 3'd3,
    CFG_LINGER  = 3'd4
  } cfg_idx_e;

  // Transaction state codes as shown in state_now.
  localparam logic [2:0] STATE_NONE       = 3'd0;
  localparam logic [2:0] STATE_TRYING     = 3'd1;
  localparam logic [2:0] STATE_PROCEEDING = 3'd2;
  localparam logic [2:0] STATE_COMPLETED  = 3'd3;
  localparam logic [2:0] STATE_TERMINATED = 3'd4;

  // Notification kinds.
  localparam logic [1:0] KIND_RESPONSE = 2'd0;
  localparam logic [1:0] KIND_TIMEOUT  = 2'd1;
  localparam logic [1:0] KIND_TXFAIL   = 2'd2;

  // Provisional response code range.
  localparam logic [9:0] RSP_PROV_LO  = 10'd100;
  localparam logic [9:0] RSP_FINAL_LO = 10'd200;

  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register bank contents.
  typedef struct packed {
    logic        use_udp;
    logic [15:0] t1_ticks;
    logic [15:0] t2_ticks;
    logic [15:0] timeout_ticks;
    logic [15:0] linger_ticks;
  } cfg_t;

  // One input item.
  typedef struct packed {
    logic [1:0] op;
    logic       is_request;
    logic [9:0] rsp_code;
    logic       tx_ok;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       send_request;
    logic       notify_tu;
    logic [1:0] notify_kind;
    logic [2:0] state_now;
    logic       status;
  } out_item_t;

endpackage

// ===== sv/non_invite_client_transaction_fsm_top.sv =====
// ----------------------------------------------------------------------------
// non_invite_client_transaction_fsm_top
// Client side of a non-INVITE request transaction with internal timers.
// ----------------------------------------------------------------------------
// Each accepted item (user request, peer message, tick or transport failure)
// gives exactly one result item. An accepted item is first held in the input
// register. The state machine then works on it and loads its result into the
// output register once that register is free or drains; the result is offered
// there until it is taken. One item can be taken every cycle while results
// drain. While a result is stalled, the input register can still take one more
// item, and after that the input side waits until the result is taken. Timers
// E, F and K count tick items, not clock cycles. Configuration writes take
// effect on the next item processed.
`timescale 1ns / 1ps

module non_invite_client_transaction_fsm_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_idx_i,
  input  logic [nictf_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  nictf_pkg::in_item_t                 in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output nictf_pkg::out_item_t                out_item_o
);
  import nictf_pkg::*;

  cfg_t     cfg;
  logic     in_valid_q;
  in_item_t in_item_q;
  logic     fsm_ready;

  nictf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Input register: refills whenever its item moves on or it is empty.
  assign in_ready_o = !in_valid_q || fsm_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
  end

  nictf_fsm u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (in_valid_q),
    .item_i       (in_item_q),
    .item_ready_o (fsm_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

// ===== sv/nictf_cfg.sv =====
// ----------------------------------------------------------------------------
// nictf_cfg
// Configuration register bank with plain indexed writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nictf_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_idx_i,
  input  logic [nictf_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output nictf_pkg::cfg_t                     cfg_o
);
  import nictf_pkg::*;

  cfg_t cfg_q;

  // Registers come out of reset with their documented defaults.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_udp       <= 1'b1;
      cfg_q.t1_ticks      <= 16'd500;
      cfg_q.t2_ticks      <= 16'd4000;
      cfg_q.timeout_ticks <= 16'd32000;
      cfg_q.linger_ticks  <= 16'd5000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_USE_UDP: cfg_q.use_udp       <= cfg_wdata_i[0];
        CFG_T1:      cfg_q.t1_ticks      <= cfg_wdata_i;
        CFG_T2:      cfg_q.t2_ticks      <= cfg_wdata_i;
        CFG_TIMEOUT: cfg_q.timeout_ticks <= cfg_wdata_i;
        CFG_LINGER:  cfg_q.linger_ticks  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/nictf_fsm.sv =====
// ----------------------------------------------------------------------------
// nictf_fsm
// Transaction state machine with timers E, F and K and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nictf_fsm (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nictf_pkg::cfg_t       cfg_i,
  input  logic                  item_valid_i,
  input  nictf_pkg::in_item_t   item_i,
  output logic                  item_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output nictf_pkg::out_item_t  out_item_o
);
  import nictf_pkg::*;

  typedef enum logic [2:0] {
    PH_NONE       = STATE_NONE,
    PH_TRYING     = STATE_TRYING,
    PH_PROCEEDING = STATE_PROCEEDING,
    PH_COMPLETED  = STATE_COMPLETED,
    PH_TERMINATED = STATE_TERMINATED
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] rt_left_q, rt_left_d;
  logic [15:0] rt_int_q, rt_int_d;
  logic [15:0] to_left_q, to_left_d;
  logic [15:0] lg_left_q, lg_left_d;
  logic        out_valid_q;
  out_item_t   out_item_q, out_item_d;

  logic        fire;
  logic        e_exp, f_exp, k_exp;
  logic [15:0] rt_dec, to_dec, lg_dec;
  logic [16:0] rt_dbl;
  logic [15:0] rt_next_int;
  logic        is_prov;

  // A new item is processed whenever the result register is free or drains.
  assign item_ready_o = !out_valid_q || out_ready_i;
  assign fire         = item_valid_i && item_ready_o;

  // Timer steps: a stopped timer stays at zero, a running one expires at one.
  assign rt_dec = (rt_left_q == '0) ? '0 : rt_left_q - 16'd1;
  assign to_dec = (to_left_q == '0) ? '0 : to_left_q - 16'd1;
  assign lg_dec = (lg_left_q == '0) ? '0 : lg_left_q - 16'd1;
  assign e_exp  = (rt_left_q == 16'd1);
  assign f_exp  = (to_left_q == 16'd1);
  assign k_exp  = (lg_left_q == 16'd1);

  // Doubled retransmit interval, capped at T2.
  assign rt_dbl      = {rt_int_q, 1'b0};
  assign rt_next_int = (rt_dbl < {1'b0, cfg_i.t2_ticks}) ? rt_dbl[15:0] : cfg_i.t2_ticks;

  assign is_prov = (item_i.rsp_code >= RSP_PROV_LO) && (item_i.rsp_code < RSP_FINAL_LO);

  // Next state and result for the item in the input register.
  always_comb begin
    phase_d   = phase_q;
    rt_left_d = rt_left_q;
    rt_int_d  = rt_int_q;
    to_left_d = to_left_q;
    lg_left_d = lg_left_q;
    out_item_d              = '0;
    out_item_d.notify_kind  = KIND_RESPONSE;

    unique case (phase_q)
      PH_NONE: begin
        if (op_e'(item_i.op) == OP_USER_REQ && item_i.is_request) begin
          out_item_d.send_request = 1'b1;
          to_left_d = cfg_i.timeout_ticks;
          if (cfg_i.use_udp) begin
            rt_int_d  = cfg_i.t1_ticks;
            rt_left_d = cfg_i.t1_ticks;
          end
          phase_d = PH_TRYING;
        end else begin
          out_item_d.status = 1'b1;
        end
      end
      PH_TRYING, PH_PROCEEDING: begin
        if (op_e'(item_i.op) == OP_PEER_MSG && !item_i.is_request) begin
          // A response is always passed up.
          out_item_d.notify_tu = 1'b1;
          if (is_prov) begin
            phase_d = PH_PROCEEDING;
          end else begin
            rt_left_d = '0;
            to_left_d = '0;
            if (cfg_i.use_udp) begin
              lg_left_d = cfg_i.linger_ticks;
              phase_d   = PH_COMPLETED;
            end else begin
              lg_left_d = '0;
              phase_d   = PH_TERMINATED;
            end
          end
        end else if (op_e'(item_i.op) == OP_TICK) begin
          rt_left_d = rt_dec;
          to_left_d = to_dec;
          // Timeout takes priority over a retransmission on the same tick.
          if (f_exp) begin
            rt_left_d = '0;
            to_left_d = '0;
            lg_left_d = '0;
            out_item_d.notify_tu   = 1'b1;
            out_item_d.notify_kind = KIND_TIMEOUT;
            phase_d = PH_TERMINATED;
          end else if (e_exp) begin
            out_item_d.send_request = 1'b1;
            if (!item_i.tx_ok) begin
              rt_left_d = '0;
              to_left_d = '0;
              lg_left_d = '0;
              out_item_d.notify_tu   = 1'b1;
              out_item_d.notify_kind = KIND_TXFAIL;
              phase_d = PH_TERMINATED;
            end else if (cfg_i.use_udp) begin
              if (phase_q == PH_TRYING) begin
                rt_int_d  = rt_next_int;
                rt_left_d = rt_next_int;
              end else begin
                rt_int_d  = cfg_i.t2_ticks;
                rt_left_d = cfg_i.t2_ticks;
              end
            end
          end
        end
      end
      PH_COMPLETED: begin
        if (op_e'(item_i.op) == OP_TICK) begin
          lg_left_d = lg_dec;
          if (k_exp) begin
            rt_left_d = '0;
            to_left_d = '0;
            phase_d   = PH_TERMINATED;
          end
        end
      end
      default: begin
        // Terminated, and codes that are never reached.
        out_item_d.status = 1'b1;
      end
    endcase

    out_item_d.state_now = phase_d;
  end

  // State, timers and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_NONE;
      rt_left_q   <= '0;
      rt_int_q    <= '0;
      to_left_q   <= '0;
      lg_left_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q     <= phase_d;
        rt_left_q   <= rt_left_d;
        rt_int_q    <= rt_int_d;
        to_left_q   <= to_left_d;
        lg_left_q   <= lg_left_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== sv/nictf_checker.sv =====
// ----------------------------------------------------------------------------
// nictf_checker
// Port-level assertions for the transaction block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "non_invite_client_transaction_fsm_top_macros.svh"

module nictf_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_o,
  input  nictf_pkg::in_item_t                 in_item_i,
  input  logic                                out_valid_o,
  input  logic                                out_ready_i,
  input  nictf_pkg::out_item_t                out_item_o
);
  import nictf_pkg::*;

  logic in_stall;
  logic out_stall;
  logic bad_action;
  logic stray_kind;
  logic rejected;
  logic idle_state;

  // Conditions watched by the assertions below.
  assign in_stall   = in_valid_i && !in_ready_o;
  assign out_stall  = out_valid_o && !out_ready_i;
  assign bad_action = out_valid_o && out_item_o.status &&
                      (out_item_o.send_request || out_item_o.notify_tu);
  assign stray_kind = out_valid_o && !out_item_o.notify_tu &&
                      (out_item_o.notify_kind != KIND_RESPONSE);
  assign rejected   = out_valid_o && out_item_o.status;
  assign idle_state = (out_item_o.state_now == STATE_NONE) ||
                      (out_item_o.state_now == STATE_TERMINATED);

  // A waiting input item stays offered and unchanged.
  `NICTF_ASSERT(a_in_hold, in_stall |=> in_valid_i && $stable(in_item_i), "input item moved")

  // A stalled result stays offered and unchanged.
  `NICTF_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable(out_item_o), "result moved")

  // A rejected event causes no transmission and no notification.
  `NICTF_ASSERT_NEVER(a_bad_quiet, bad_action, "rejected event caused an action")

  // Without a notification the kind reads as zero.
  `NICTF_ASSERT_NEVER(a_kind_idle, stray_kind, "notify kind set without notification")

  // Events are only rejected before the first request or after termination.
  `NICTF_ASSERT(a_bad_state, rejected |-> idle_state, "rejected event in an active state")

endmodule

bind non_invite_client_transaction_fsm_top nictf_checker u_nictf_checker (.*);
